// ===== rtl/evsf_pkg.sv =====
// Shared types and constants for the encoder velocity spike filter.
`timescale 1ns / 1ps
`default_nettype none

package evsf_pkg;

    localparam int COUNT_W = 32;
    localparam int DELTA_W = 16;
    localparam int LIMIT_W = 15;
    localparam int SCALE_W = 32;
    localparam int RPM_W   = 32;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_SPIKE_LIMIT = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_RPM_SCALE   = 1'b1;

    localparam logic REQ_TICK  = 1'b0;
    localparam logic REQ_CLEAR = 1'b1;

    localparam logic [LIMIT_W-1:0] RESET_SPIKE_LIMIT = 15'd75;
    localparam logic [SCALE_W-1:0] RESET_RPM_SCALE   = 32'd65536;

    typedef struct packed {
        logic adv;
        logic clr;
    } t_flt_ctl;

endpackage

`default_nettype wire

// ===== rtl/evsf_chan_filter.sv =====
// One channel: wrapping count difference, spike rejection and history.
`timescale 1ns / 1ps
`default_nettype none

module evsf_chan_filter
    import evsf_pkg::*;
(
    input  wire                        i_clk,
    input  wire                        i_rst_n,
    input  t_flt_ctl                   i_ctl,
    input  wire  [LIMIT_W-1:0]         i_limit,
    input  wire  [COUNT_W-1:0]         i_count,
    output logic signed [DELTA_W-1:0]  o_delta
);

    logic [COUNT_W-1:0]        r_prev_count;
    logic signed [DELTA_W-1:0] r_prev_delta;
    logic [COUNT_W-1:0]        w_diff;
    logic [COUNT_W-1:0]        w_mag;
    logic                      w_spike;
    logic signed [DELTA_W-1:0] n_delta;

    always_comb begin
        w_diff  = i_count - r_prev_count;
        w_mag   = w_diff[COUNT_W-1] ? (COUNT_W'(0) - w_diff) : w_diff;
        w_spike = w_mag > {{(COUNT_W-LIMIT_W){1'b0}}, i_limit};
        if (i_ctl.clr) begin
            n_delta = '0;
        end else if (w_spike) begin
            n_delta = r_prev_delta;
        end else begin
            n_delta = w_diff[DELTA_W-1:0];
        end
    end

    assign o_delta = n_delta;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_count <= '0;
            r_prev_delta <= '0;
        end else if (i_ctl.adv) begin
            r_prev_count <= i_ctl.clr ? '0 : i_count;
            r_prev_delta <= n_delta;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/evsf_rpm_scale.sv =====
// Three-stage delta times Q16.16 scale, round to Q24.8 and saturate.
`timescale 1ns / 1ps
`default_nettype none

module evsf_rpm_scale
    import evsf_pkg::*;
(
    input  wire                        i_clk,
    input  wire                        i_en,
    input  wire  signed [DELTA_W-1:0]  i_delta,
    input  wire  [SCALE_W-1:0]         i_scale,
    output logic [RPM_W-1:0]           o_rpm
);

    localparam int MAG_W  = DELTA_W - 1;
    localparam int PROD_W = MAG_W + SCALE_W;
    localparam int Q_W    = PROD_W + 1 - 8;

    logic [DELTA_W-1:0] w_neg_delta;
    logic [MAG_W-1:0]   w_mag;
    logic [PROD_W:0]    w_sum;
    logic [Q_W-1:0]     w_q;
    logic               w_pos_ovf;
    logic               w_neg_ovf;
    logic [RPM_W-1:0]   n_rpm;

    logic [PROD_W-1:0]  r_prod;
    logic               r_neg1;
    logic [Q_W-1:0]     r_q;
    logic               r_neg2;
    logic [RPM_W-1:0]   r_rpm;

    always_comb begin
        w_neg_delta = DELTA_W'(0) - i_delta;
        w_mag       = i_delta[DELTA_W-1] ? w_neg_delta[MAG_W-1:0] : i_delta[MAG_W-1:0];
        w_sum       = {1'b0, r_prod} + (PROD_W+1)'(128);
        w_q         = w_sum[PROD_W:8];
        w_pos_ovf   = |r_q[Q_W-1:RPM_W-1];
        w_neg_ovf   = (|r_q[Q_W-1:RPM_W]) || (r_q[RPM_W-1] && (|r_q[RPM_W-2:0]));
        if (r_neg2) begin
            n_rpm = w_neg_ovf ? {1'b1, {(RPM_W-1){1'b0}}} : (RPM_W'(0) - r_q[RPM_W-1:0]);
        end else begin
            n_rpm = w_pos_ovf ? {1'b0, {(RPM_W-1){1'b1}}} : r_q[RPM_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod <= PROD_W'(w_mag) * PROD_W'(i_scale);
            r_neg1 <= i_delta[DELTA_W-1];
            r_q    <= w_q;
            r_neg2 <= r_neg1;
            r_rpm  <= n_rpm;
        end
    end

    assign o_rpm = r_rpm;

endmodule

`default_nettype wire

// ===== rtl/encoder_velocity_spike_filter_top.sv =====
// Top level: stream ports, configuration registers and stage control.
//
//  port group    dir  payload
//  s_axis        in   tdata {right_count, left_count}, tuser {req_type}
//  m_axis        out  tdata {right_rpm, left_rpm, right_delta, left_delta}
//  i_cfg         in   index 0 spike_limit, index 1 rpm_scale
//
//  One item per cycle while no result is held; five register stages (input,
//  delta, product, round, result) lie between the transfer and the result.
//  The multiplier stage per channel sets the depth.
//  Synchronous active-low reset clears counts, history and valid bits.
//  A held result freezes every stage; s_axis_tready drops with it.
`timescale 1ns / 1ps
`default_nettype none

module encoder_velocity_spike_filter_top
    import evsf_pkg::*;
(
    input  wire                     i_clk,
    input  wire                     i_rst_n,
    input  wire                     s_axis_tvalid,
    output logic                    s_axis_tready,
    input  wire  [63:0]             s_axis_tdata,   // left_count, right_count
    input  wire  [0:0]              s_axis_tuser,   // req_type
    output logic                    m_axis_tvalid,
    input  wire                     m_axis_tready,
    output logic [95:0]             m_axis_tdata,   // left_delta, right_delta, left_rpm, right_rpm
    input  wire                     i_cfg_we,
    input  wire  [CFG_IDX_W-1:0]    i_cfg_addr,
    input  wire  [CFG_DATA_W-1:0]   i_cfg_data
);

    logic                      w_adv;
    t_flt_ctl                  w_ctl;

    logic [LIMIT_W-1:0]        r_spike_limit;
    logic [SCALE_W-1:0]        r_rpm_scale;

    logic                      r_in_valid;
    logic                      r_in_clr;
    logic [COUNT_W-1:0]        r_in_left;
    logic [COUNT_W-1:0]        r_in_right;

    logic signed [DELTA_W-1:0] w_ld;
    logic signed [DELTA_W-1:0] w_rd;

    logic                      r_d_valid;
    logic signed [DELTA_W-1:0] r_d_left;
    logic signed [DELTA_W-1:0] r_d_right;
    logic                      r_p_valid;
    logic signed [DELTA_W-1:0] r_p_left;
    logic signed [DELTA_W-1:0] r_p_right;
    logic                      r_q_valid;
    logic signed [DELTA_W-1:0] r_q_left;
    logic signed [DELTA_W-1:0] r_q_right;
    logic                      r_o_valid;
    logic signed [DELTA_W-1:0] r_o_left;
    logic signed [DELTA_W-1:0] r_o_right;

    logic [RPM_W-1:0]          w_lrpm;
    logic [RPM_W-1:0]          w_rrpm;

    assign w_adv         = !r_o_valid || m_axis_tready;
    assign s_axis_tready = w_adv;
    assign w_ctl.adv     = w_adv && r_in_valid;
    assign w_ctl.clr     = r_in_clr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_spike_limit <= RESET_SPIKE_LIMIT;
            r_rpm_scale   <= RESET_RPM_SCALE;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                CFG_SPIKE_LIMIT: r_spike_limit <= i_cfg_data[LIMIT_W-1:0];
                CFG_RPM_SCALE:   r_rpm_scale   <= i_cfg_data[SCALE_W-1:0];
                default:         r_rpm_scale   <= r_rpm_scale;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
            r_d_valid  <= 1'b0;
            r_p_valid  <= 1'b0;
            r_q_valid  <= 1'b0;
            r_o_valid  <= 1'b0;
        end else if (w_adv) begin
            r_in_valid <= s_axis_tvalid;
            r_d_valid  <= r_in_valid;
            r_p_valid  <= r_d_valid;
            r_q_valid  <= r_p_valid;
            r_o_valid  <= r_q_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_in_clr   <= (s_axis_tuser[0] == REQ_CLEAR);
            r_in_left  <= s_axis_tdata[COUNT_W-1:0];
            r_in_right <= s_axis_tdata[2*COUNT_W-1:COUNT_W];
            r_d_left   <= w_ld;
            r_d_right  <= w_rd;
            r_p_left   <= r_d_left;
            r_p_right  <= r_d_right;
            r_q_left   <= r_p_left;
            r_q_right  <= r_p_right;
            r_o_left   <= r_q_left;
            r_o_right  <= r_q_right;
        end
    end

    evsf_chan_filter u_flt_left (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_ctl),
        .i_limit (r_spike_limit),
        .i_count (r_in_left),
        .o_delta (w_ld)
    );

    evsf_chan_filter u_flt_right (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_ctl),
        .i_limit (r_spike_limit),
        .i_count (r_in_right),
        .o_delta (w_rd)
    );

    evsf_rpm_scale u_rpm_left (
        .i_clk   (i_clk),
        .i_en    (w_adv),
        .i_delta (r_d_left),
        .i_scale (r_rpm_scale),
        .o_rpm   (w_lrpm)
    );

    evsf_rpm_scale u_rpm_right (
        .i_clk   (i_clk),
        .i_en    (w_adv),
        .i_delta (r_d_right),
        .i_scale (r_rpm_scale),
        .o_rpm   (w_rrpm)
    );

    assign m_axis_tvalid = r_o_valid;
    assign m_axis_tdata  = {w_rrpm, w_lrpm, r_o_right, r_o_left};

    a_clear_zeros: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_adv && r_in_valid && r_in_clr) |=> (r_d_valid && r_d_left == 0 && r_d_right == 0))
        else $error("clear transfer did not give zero deltas");

    a_delta_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_d_valid |-> (r_d_left != 16'sh8000 && r_d_right != 16'sh8000))
        else $error("filtered delta out of range");

    a_zero_rpm: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_o_valid && r_o_left == 0) |-> (w_lrpm == 0))
        else $error("zero left delta gave nonzero speed");

    a_rpm_sign: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_o_valid && w_rrpm[RPM_W-1]) |-> r_o_right[DELTA_W-1])
        else $error("right speed sign disagrees with delta");

endmodule

`default_nettype wire

// ===== sim/evsf_rpm_checker.sv =====
// Scoreboard for the encoder velocity spike filter: predicts deltas and RPM, checks results.
`timescale 1ns / 1ps

module evsf_rpm_checker
    import evsf_pkg::*;
(
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   i_s_tvalid,
    input  wire                   i_s_tready,
    input  wire  [63:0]           i_s_tdata,    // left_count, right_count
    input  wire  [0:0]            i_s_tuser,    // req_type
    input  wire                   i_m_tvalid,
    input  wire                   i_m_tready,
    input  wire  [95:0]           i_m_tdata,    // left_delta, right_delta, left_rpm, right_rpm
    input  wire                   i_cfg_we,
    input  wire  [CFG_IDX_W-1:0]  i_cfg_addr,
    input  wire  [CFG_DATA_W-1:0] i_cfg_data,
    output int                    o_fail_count,
    output int                    o_pending
);

    localparam int   REPORT_MAX = 10;

    typedef struct packed {
        logic [RPM_W-1:0]          right_rpm;
        logic [RPM_W-1:0]          left_rpm;
        logic signed [DELTA_W-1:0] right_delta;
        logic signed [DELTA_W-1:0] left_delta;
    } t_speed_rec;

    t_speed_rec                speed_queue[$];
    t_speed_rec                got;
    t_speed_rec                want;
    logic [LIMIT_W-1:0]        limit_q = RESET_SPIKE_LIMIT;
    logic [SCALE_W-1:0]        scale_q = RESET_RPM_SCALE;
    logic [COUNT_W-1:0]        last_l_cnt = '0;
    logic [COUNT_W-1:0]        last_r_cnt = '0;
    logic signed [DELTA_W-1:0] last_l_dlt = '0;
    logic signed [DELTA_W-1:0] last_r_dlt = '0;
    int                        fail_total = 0;

    assign o_fail_count = fail_total;

    function automatic logic signed [DELTA_W-1:0] filter_delta(
        input logic [COUNT_W-1:0]        now_cnt,
        input logic [COUNT_W-1:0]        prev_cnt,
        input logic signed [DELTA_W-1:0] prev_dlt,
        input logic [LIMIT_W-1:0]        lim
    );
        logic [COUNT_W-1:0] diff;
        logic [COUNT_W-1:0] mag;
        diff = now_cnt - prev_cnt;
        mag  = diff[COUNT_W-1] ? (~diff + 1'b1) : diff;
        if (mag > COUNT_W'(lim))
            return prev_dlt;
        return diff[DELTA_W-1:0];
    endfunction

    // Q16.16 product rounded half away from zero to Q24.8, then saturated.
    function automatic logic [RPM_W-1:0] scale_to_rpm(
        input logic signed [DELTA_W-1:0] dlt,
        input logic [SCALE_W-1:0]        scale
    );
        logic [DELTA_W-1:0] mag;
        logic [48:0]        prod_r;
        logic [40:0]        q;
        mag    = dlt[DELTA_W-1] ? (~dlt + 1'b1) : dlt;
        prod_r = 49'(mag) * 49'(scale) + 49'd128;
        q      = prod_r[48:8];
        if (dlt[DELTA_W-1])
            return (q > 41'h0_8000_0000) ? 32'h8000_0000 : (~q[31:0] + 1'b1);
        return (q > 41'h0_7FFF_FFFF) ? 32'h7FFF_FFFF : q[31:0];
    endfunction

    task automatic check_field(input string name, input logic [31:0] exp_v,
                               input logic [31:0] act_v);
        if (exp_v !== act_v) begin
            fail_total++;
            if (fail_total <= REPORT_MAX)
                $display("%0t: %s mismatch, expected %h, got %h", $realtime, name, exp_v, act_v);
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            limit_q    = RESET_SPIKE_LIMIT;
            scale_q    = RESET_RPM_SCALE;
            last_l_cnt = '0;
            last_r_cnt = '0;
            last_l_dlt = '0;
            last_r_dlt = '0;
            speed_queue.delete();
        end else begin
            if (i_m_tvalid && i_m_tready) begin
                got = t_speed_rec'(i_m_tdata);
                if (speed_queue.size() == 0) begin
                    fail_total++;
                    if (fail_total <= REPORT_MAX)
                        $display("%0t: result with nothing expected, got %h", $realtime, got);
                end else begin
                    want = speed_queue.pop_front();
                    check_field("left_delta", 32'(want.left_delta), 32'(got.left_delta));
                    check_field("right_delta", 32'(want.right_delta), 32'(got.right_delta));
                    check_field("left_rpm", want.left_rpm, got.left_rpm);
                    check_field("right_rpm", want.right_rpm, got.right_rpm);
                end
            end
            if (i_s_tvalid && i_s_tready) begin
                if (i_s_tuser[0] == REQ_CLEAR) begin
                    last_l_cnt = '0;
                    last_r_cnt = '0;
                    last_l_dlt = '0;
                    last_r_dlt = '0;
                    want       = '0;
                end else begin
                    want.left_delta  = filter_delta(i_s_tdata[31:0], last_l_cnt, last_l_dlt,
                                                    limit_q);
                    want.right_delta = filter_delta(i_s_tdata[63:32], last_r_cnt, last_r_dlt,
                                                    limit_q);
                    last_l_cnt       = i_s_tdata[31:0];
                    last_r_cnt       = i_s_tdata[63:32];
                    last_l_dlt       = want.left_delta;
                    last_r_dlt       = want.right_delta;
                    want.left_rpm    = scale_to_rpm(want.left_delta, scale_q);
                    want.right_rpm   = scale_to_rpm(want.right_delta, scale_q);
                end
                speed_queue.push_back(want);
            end
            if (i_cfg_we) begin
                if (i_cfg_addr == CFG_SPIKE_LIMIT)
                    limit_q = i_cfg_data[LIMIT_W-1:0];
                else if (i_cfg_addr == CFG_RPM_SCALE)
                    scale_q = i_cfg_data[SCALE_W-1:0];
            end
        end
        o_pending <= speed_queue.size();
    end

endmodule

// ===== sim/tb.sv =====
// Testbench top for the encoder velocity spike filter: reset, stimulus, flow control and verdict.
`timescale 1ns / 1ps

module tb
    import evsf_pkg::*;
();

    localparam int   PHASES          = 8;
    localparam int   ITEMS_PER_PHASE = 228;
    localparam int   RX_HOLD_CYCLES  = 300;
    localparam int   DRAIN_CYCLES    = 8;

    logic                  i_clk         = 1'b0;
    logic                  i_rst_n       = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    wire                   s_axis_tready;
    logic [63:0]           s_axis_tdata  = '0;    // left_count, right_count
    logic [0:0]            s_axis_tuser  = '0;    // req_type
    wire                   m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    wire  [95:0]           m_axis_tdata;          // left_delta, right_delta, left_rpm, right_rpm
    logic                  i_cfg_we      = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_addr    = CFG_SPIKE_LIMIT;
    logic [CFG_DATA_W-1:0] i_cfg_data    = '0;

    int                    fail_count;
    int                    pending;
    int                    src_idle_pct  = 0;
    int                    rx_stall_pct  = 0;
    int                    rx_hold_reqs  = 0;
    int                    rx_hold_seen  = 0;
    int                    rx_hold_left  = 0;
    int                    gen_limit     = 75;
    logic [COUNT_W-1:0]    cur_l         = '0;
    logic [COUNT_W-1:0]    cur_r         = '0;

    always #6 i_clk = ~i_clk;

    encoder_velocity_spike_filter_top dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_data    (i_cfg_data)
    );

    evsf_rpm_checker u_rpm_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_s_tvalid   (s_axis_tvalid),
        .i_s_tready   (s_axis_tready),
        .i_s_tdata    (s_axis_tdata),
        .i_s_tuser    (s_axis_tuser),
        .i_m_tvalid   (m_axis_tvalid),
        .i_m_tready   (m_axis_tready),
        .i_m_tdata    (m_axis_tdata),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_addr   (i_cfg_addr),
        .i_cfg_data   (i_cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // Receiver: random stalls, plus a long hold-off on request.
    always @(posedge i_clk) begin
        if (rx_hold_left > 0) begin
            rx_hold_left--;
            m_axis_tready <= 1'b0;
        end else if (rx_hold_seen != rx_hold_reqs) begin
            rx_hold_seen = rx_hold_reqs;
            rx_hold_left = RX_HOLD_CYCLES;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= rx_stall_pct);
        end
    end

    task automatic send_item(input logic req, input logic [COUNT_W-1:0] lc,
                             input logic [COUNT_W-1:0] rc);
        while ($urandom_range(99) < src_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= req;
        s_axis_tdata  <= {rc, lc};
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    task automatic hold_until_drained();
        s_axis_tvalid <= 1'b0;
        do @(negedge i_clk); while (pending != 0);
        @(posedge i_clk);
    endtask

    task automatic load_regs(input logic [LIMIT_W-1:0] lim, input logic [SCALE_W-1:0] scale);
        hold_until_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_addr <= CFG_SPIKE_LIMIT;
        i_cfg_data <= CFG_DATA_W'(lim);
        @(posedge i_clk);
        i_cfg_addr <= CFG_RPM_SCALE;
        i_cfg_data <= scale;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        gen_limit  = lim;
    endtask

    function automatic logic [COUNT_W-1:0] pick_step(input int lim);
        int unsigned mag;
        case ($urandom_range(9))
            0:       mag = lim;
            1:       mag = lim + 1;
            2:       mag = $urandom_range(0, 65535);
            default: mag = $urandom_range(0, lim + lim / 8 + 1);
        endcase
        return $urandom_range(1) ? (~mag + 1) : mag;
    endfunction

    task automatic random_item();
        int sel;
        sel = $urandom_range(99);
        if (sel < 3) begin
            send_item(REQ_CLEAR, $urandom, $urandom);
            cur_l = '0;
            cur_r = '0;
        end else if (sel < 8) begin
            cur_l = $urandom;
            cur_r = $urandom;
            send_item(REQ_TICK, cur_l, cur_r);
        end else begin
            cur_l += pick_step(gen_limit);
            cur_r += pick_step(gen_limit);
            send_item(REQ_TICK, cur_l, cur_r);
        end
    endtask

    task automatic run_phase(input int idx);
        int mode;
        case (idx)
            0:       load_regs(RESET_SPIKE_LIMIT, RESET_RPM_SCALE);
            1:       load_regs('0, '1);
            2:       load_regs('1, '0);
            3:       load_regs(LIMIT_W'($urandom_range(0, 2000)), $urandom);
            4:       load_regs('1, '1);
            5:       load_regs(LIMIT_W'($urandom_range(0, 32767)), $urandom);
            6:       load_regs(LIMIT_W'($urandom_range(0, 300)), $urandom_range(0, 1 << 20));
            default: load_regs(LIMIT_W'(1), SCALE_W'(128));
        endcase
        mode         = idx % 4;
        src_idle_pct = (mode == 1) ? 61 : (mode == 3) ? 36 : 0;
        rx_stall_pct = (mode == 2) ? 61 : (mode == 3) ? 36 : 0;
        for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
            if (idx == 2 && i == 100)
                rx_hold_reqs++;
            if (idx == 5 && i == ITEMS_PER_PHASE / 2)
                hold_until_drained();
            random_item();
        end
    endtask

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_item(REQ_TICK, 32'd0, 32'd0);
        send_item(REQ_TICK, 32'd75, -32'd75);
        send_item(REQ_TICK, 32'd151, -32'd151);
        send_item(REQ_TICK, 32'h7FFF_FFFF, 32'h8000_0000);
        send_item(REQ_TICK, 32'h8000_0010, 32'h7FFF_FFF0);
        send_item(REQ_TICK, 32'h0000_0010, 32'hFFFF_FFF0);
        send_item(REQ_TICK, 32'h0000_000A, 32'hFFFF_FFFF);
        send_item(REQ_CLEAR, $urandom, $urandom);
        send_item(REQ_TICK, 32'd5000, -32'd5000);
        send_item(REQ_CLEAR, 32'hFFFF_FFFF, 32'hFFFF_FFFF);

        load_regs('1, '1);
        send_item(REQ_TICK, 32'd32767, -32'd32767);
        send_item(REQ_TICK, 32'd32768, -32'd32768);
        send_item(REQ_TICK, 32'd65536, -32'd65536);

        load_regs('0, SCALE_W'(128));
        send_item(REQ_TICK, 32'd65537, -32'd65537);
        send_item(REQ_TICK, 32'd65537, -32'd65537);
        send_item(REQ_CLEAR, 32'd0, 32'd0);
        cur_l = '0;
        cur_r = '0;

        for (int p = 0; p < PHASES; p++)
            run_phase(p);

        hold_until_drained();
        repeat (10) @(posedge i_clk);
        if (fail_count == 0)
            $display("PASS encoder_velocity_spike_filter_top");
        else
            $display("FAIL encoder_velocity_spike_filter_top");
        $finish;
    end

    initial begin
        #5_000_000;
        $display("FAIL encoder_velocity_spike_filter_top");
        $finish;
    end

endmodule
